>>> hw/rtl/btsg_pkg.sv
// shared types and constants of the block tile split generator
`default_nettype none

package btsg_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POINT_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COORD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MODE = 3'd5;

    // configuration as seen by front and back; sizes already forced to at least one
    typedef struct packed {
        logic [15:0] length;
        logic [15:0] block_size;
        logic [15:0] tile_size;
        logic [8:0]  proc_count;
        logic [7:0]  proc_coord;
        logic        local_mode;
    } cfg_t;

    // classification of one queued beat
    typedef struct packed {
        logic last;   // length point
        logic ended;  // step after the end of the list
    } item_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/block_tile_split_generator_unit.sv
// top level of the block tile split generator
`default_nettype none

// Each input beat asks for the next split point of one matrix dimension: the
// merged ascending multiples of block_size and tile_size below length, then
// length itself with last set; after that every beat returns point 0, kept 0,
// last 1 until a beat with restart. In local mode the one-bit-per-cycle
// divider in the back end runs once by block size and once by process count.
// The front end takes beats into a two-entry queue, so up to two requests
// and one finished result can be held while the back end works.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must do so only while the block is idle, which the block itself does
// not enforce; zero sizes act as one.
module block_tile_split_generator_unit #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [btsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [btsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_restart,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [btsg_pkg::POINT_W-1:0]            m_point,
    output logic                                    m_kept,
    output logic                                    m_last
);

    localparam int Q_W = INDEX_WIDTH + 2;

    btsg_pkg::cfg_t        cfg_reg, cfg_next;
    logic                  push_valid, push_ready;
    logic [INDEX_WIDTH-1:0] push_point;
    btsg_pkg::item_flags_t push_flags;
    logic                  q_valid, q_ready;
    logic [Q_W-1:0]        q_data;
    logic [INDEX_WIDTH-1:0] q_point;
    btsg_pkg::item_flags_t q_flags;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                btsg_pkg::CFG_LENGTH: cfg_next.length = cfg_wdata;
                btsg_pkg::CFG_BLOCK_SIZE:
                    cfg_next.block_size = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
                btsg_pkg::CFG_TILE_SIZE:
                    cfg_next.tile_size = (cfg_wdata == '0) ? 16'd1 : cfg_wdata;
                btsg_pkg::CFG_PROC_COUNT:
                    cfg_next.proc_count = (cfg_wdata[8:0] == '0) ? 9'd1 : cfg_wdata[8:0];
                btsg_pkg::CFG_PROC_COORD: cfg_next.proc_coord = cfg_wdata[7:0];
                btsg_pkg::CFG_LOCAL_MODE: cfg_next.local_mode = cfg_wdata[0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{length: 16'd1, block_size: 16'd1, tile_size: 16'd1,
                         proc_count: 9'd1, proc_coord: 8'd0, local_mode: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    btsg_front #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_point(push_point),
        .push_flags(push_flags)
    );

    // queue between front and back
    btsg_fifo #(
        .WIDTH(Q_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data ({push_point, push_flags}),
        .rd_valid(q_valid),
        .rd_ready(q_ready),
        .rd_data (q_data)
    );

    assign q_point = q_data[Q_W-1:2];
    assign q_flags = q_data[1:0];

    // back end
    btsg_back #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_valid(q_valid),
        .in_ready(q_ready),
        .in_point(q_point),
        .in_flags(q_flags),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_point (m_point),
        .m_kept  (m_kept),
        .m_last  (m_last)
    );

    // back end takes one queued beat and is busy the cycle after
    a_back_single_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> !q_ready)
        else $error("back end took two beats in consecutive cycles");

    // no result is shown straight out of reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a result cannot appear before anything entered the queue
    a_result_needs_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !q_ready || $past(!q_ready))
        else $error("result appeared without back end work");

endmodule

`default_nettype wire

>>> hw/rtl/btsg_fifo.sv
// two-entry queue between the front and the back
`default_nettype none

module btsg_fifo #(
    parameter int WIDTH = 18
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/btsg_front.sv
// front: walks the merged block and tile multiples, one point per beat
`default_nettype none

module btsg_front #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire btsg_pkg::cfg_t          cfg,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_restart,
    output logic                         push_valid,
    input  wire logic                    push_ready,
    output logic [INDEX_WIDTH-1:0]       push_point,
    output btsg_pkg::item_flags_t        push_flags
);

    localparam int PTR_W = INDEX_WIDTH + 1;

    logic [PTR_W-1:0] block_point_reg, block_point_next;
    logic [PTR_W-1:0] tile_point_reg, tile_point_next;
    logic             merge_done_reg, merge_done_next;
    logic             list_ended_reg, list_ended_next;

    logic [PTR_W-1:0] bp, tp, len, d, bp_adv, tp_adv;
    logic             md, le, accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;
    assign len        = PTR_W'(INDEX_WIDTH'(cfg.length));

    // one merge step
    always_comb begin
        bp = s_restart ? '0 : block_point_reg;
        tp = s_restart ? '0 : tile_point_reg;
        md = s_restart ? 1'b0 : merge_done_reg;
        le = s_restart ? 1'b0 : list_ended_reg;

        d      = (bp < tp) ? bp : tp;
        bp_adv = (bp == d) ? bp + PTR_W'(cfg.block_size) : bp;
        tp_adv = (tp == d) ? tp + PTR_W'(cfg.tile_size) : tp;

        block_point_next = bp;
        tile_point_next  = tp;
        merge_done_next  = md;
        list_ended_next  = le;
        push_point       = '0;
        push_flags       = '{last: 1'b0, ended: 1'b0};

        priority if (le) begin
            push_flags.ended = 1'b1;
        end else if (!md && (bp < len || tp < len)) begin
            block_point_next = bp_adv;
            tile_point_next  = tp_adv;
            merge_done_next  = (bp_adv >= len) && (tp_adv >= len);
            push_point       = INDEX_WIDTH'(d);
        end else begin
            merge_done_next  = 1'b1;
            list_ended_next  = 1'b1;
            push_point       = INDEX_WIDTH'(len);
            push_flags.last  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_point_reg <= '0;
            tile_point_reg  <= '0;
            merge_done_reg  <= 1'b0;
            list_ended_reg  <= 1'b0;
        end else if (accept) begin
            block_point_reg <= block_point_next;
            tile_point_reg  <= tile_point_next;
            merge_done_reg  <= merge_done_next;
            list_ended_reg  <= list_ended_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/btsg_back.sv
// back: owner filter and local index through a shared serial divider
`default_nettype none

module btsg_back #(
    parameter int INDEX_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire btsg_pkg::cfg_t         cfg,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [INDEX_WIDTH-1:0] in_point,
    input  wire btsg_pkg::item_flags_t  in_flags,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [btsg_pkg::POINT_W-1:0] m_point,
    output logic                        m_kept,
    output logic                        m_last
);

    localparam int CNT_W = $clog2(INDEX_WIDTH);
    localparam int PW    = btsg_pkg::POINT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [INDEX_WIDTH-1:0] quo_reg, quo_next;
    logic [15:0]            rem_reg, rem_next;
    logic [15:0]            div_reg, div_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pass_reg, pass_next;
    logic [15:0]            r1_reg, r1_next;
    logic [PW-1:0]          pt_reg, pt_next;
    logic                   kept_reg, kept_next;
    logic                   last_reg, last_next;
    logic                   m_valid_reg, m_valid_next;
    logic [PW-1:0]          m_point_reg, m_point_next;
    logic                   m_kept_reg, m_kept_next;
    logic                   m_last_reg, m_last_next;

    logic [16:0]            trial;
    logic                   ge;
    logic [15:0]            rem_step;
    logic [INDEX_WIDTH-1:0] quo_step;
    logic [PW-1:0]          prod_full;

    assign in_ready = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_point  = m_point_reg;
    assign m_kept   = m_kept_reg;
    assign m_last   = m_last_reg;

    // restoring divider step, one quotient bit a cycle
    assign trial    = {rem_reg, quo_reg[INDEX_WIDTH-1]};
    assign ge       = (trial >= {1'b0, div_reg});
    assign rem_step = ge ? 16'(trial - {1'b0, div_reg}) : trial[15:0];
    assign quo_step = {quo_reg[INDEX_WIDTH-2:0], ge};

    // block quotient over process count, scaled back by block size
    assign prod_full = PW'(quo_reg) * cfg.block_size;

    always_comb begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        cnt_next     = cnt_reg;
        pass_next    = pass_reg;
        r1_next      = r1_reg;
        pt_next      = pt_reg;
        kept_next    = kept_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_point_next = m_point_reg;
        m_kept_next  = m_kept_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    r1_next   = '0;
                    last_next = in_flags.last;
                    priority if (in_flags.ended) begin
                        pt_next    = '0;
                        kept_next  = 1'b0;
                        last_next  = 1'b1;
                        state_next = ST_FIN;
                    end else if (!cfg.local_mode) begin
                        pt_next    = PW'(in_point);
                        kept_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        quo_next   = in_point;
                        rem_next   = '0;
                        div_next   = cfg.block_size;
                        cnt_next   = '0;
                        pass_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(INDEX_WIDTH - 1)) begin
                    cnt_next = '0;
                    if (!pass_reg) begin
                        // block index in hand, now divide by process count
                        r1_next   = rem_step;
                        rem_next  = '0;
                        div_next  = 16'(cfg.proc_count);
                        pass_next = 1'b1;
                    end else begin
                        kept_next  = (rem_step == 16'(cfg.proc_coord));
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                pt_next    = prod_full;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_point_next = pt_reg + r1_reg;
                    m_kept_next  = kept_reg;
                    m_last_next  = last_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        cnt_reg     <= cnt_next;
        pass_reg    <= pass_next;
        r1_reg      <= r1_next;
        pt_reg      <= pt_next;
        kept_reg    <= kept_next;
        last_reg    <= last_next;
        m_point_reg <= m_point_next;
        m_kept_reg  <= m_kept_next;
        m_last_reg  <= m_last_next;
    end

endmodule

`default_nettype wire
